@@ rtl/core/ltmf_pkg.sv @@
// Package for the light trimmed mean filter.
// Holds the sizes, reset values, codes and the controller/datapath link types.
// No dependencies.
package ltmf_pkg;

  localparam int WIN_SIZE = 40;
  localparam int CNT_W    = $clog2(WIN_SIZE + 1);
  localparam int PCT_W    = 7;
  localparam int RAW_W    = 16;
  localparam int TRIM_W   = 5;
  localparam int PER_W    = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_AW   = 2;
  localparam int THR_W    = TRIM_W + 2;
  localparam int PCT_FULL = 100;
  localparam int SUM_W    = $clog2(WIN_SIZE * PCT_FULL + 1);

  localparam int DIV_DW   = RAW_W + PCT_W;
  localparam int DIV_VW   = 16;
  localparam int DIV_CW   = $clog2(DIV_DW);

  localparam int GRP_N    = 8;
  localparam int GRP_CNT  = (WIN_SIZE + GRP_N - 1) / GRP_N;
  localparam int GRP_W    = $clog2(GRP_N + 1);

  localparam logic [RAW_W-1:0]  FS_RST   = RAW_W'(50);
  localparam logic [TRIM_W-1:0] TRIM_RST = TRIM_W'(6);
  localparam logic [PER_W-1:0]  PLOW_RST = PER_W'(110);
  localparam logic [PER_W-1:0]  PHI_RST  = PER_W'(269);

  typedef enum logic [CFG_AW-1:0] {
    CFG_FULL_SCALE,
    CFG_TRIM,
    CFG_PER_LOW,
    CFG_PER_HIGH
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIV_PCT,
    DIV_MEAN,
    DIV_PER
  } div_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PCT_GO,
    ST_PCT_WAIT,
    ST_PUSH,
    ST_RANK,
    ST_DRAIN,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_PER_GO,
    ST_PER_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic    load_in;
    logic    div_start;
    div_op_t div_op;
    logic    push;
    logic    rank_step;
    logic    emit;
  } cmd_t;

  typedef struct packed {
    logic add_sample;
    logic div_done;
    logic rot_last;
    logic rank_busy;
    logic n_zero;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/ltmf_in_if.sv @@
// Input channel of the light trimmed mean filter: mode and raw sensor count.
// Depends on ltmf_pkg.
interface ltmf_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [ltmf_pkg::RAW_W-1:0] raw_count;

  modport source (output valid, output mode, output raw_count, input ready);
  modport sink   (input valid, input mode, input raw_count, output ready);
endinterface

@@ rtl/core/ltmf_out_if.sv @@
// Result channel of the light trimmed mean filter.
// Depends on ltmf_pkg.
interface ltmf_out_if;
  logic                       valid;
  logic                       ready;
  logic [ltmf_pkg::PCT_W-1:0] filtered_percent;
  logic [ltmf_pkg::PCT_W-1:0] latest_percent;
  logic [ltmf_pkg::PER_W-1:0] timer_period;
  logic [ltmf_pkg::CNT_W-1:0] held_samples;

  modport source (output valid, output filtered_percent, output latest_percent,
                  output timer_period, output held_samples, input ready);
  modport sink   (input valid, input filtered_percent, input latest_percent,
                  input timer_period, input held_samples, output ready);
endinterface

@@ rtl/core/light_trimmed_mean_filter.sv @@
// Top level of the light trimmed mean filter.
// Depends on ltmf_pkg, ltmf_in_if, ltmf_out_if, ltmf_ctrl and ltmf_datapath.
//
//   channel  dir  handshake        word
//   in_ch    in   valid/ready      mode, raw_count
//   out_ch   out  valid/ready      filtered_percent, latest_percent,
//                                  timer_period, held_samples
//   cfg_*    in   cfg_we only      cfg_addr selects register, cfg_wdata value
//
// The rank pass over all 40 window slots and the shared divider (used three
// times for a sample word, at most twice for a report-only word) dominate the
// work per word. One word is in work at a time.
// Synchronous active-low reset restores register defaults and empties the
// window. A finished result waits in the output register while the next word
// is accepted; a stalled output holds the block only at the final handoff.
module light_trimmed_mean_filter (
  input  logic                        clk,
  input  logic                        rst_n,
  ltmf_in_if.sink                     in_ch,
  ltmf_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [ltmf_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [ltmf_pkg::CFG_W-1:0]  cfg_wdata
);

  ltmf_pkg::cmd_t cmd;
  ltmf_pkg::sts_t sts;

  ltmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ltmf_datapath u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_we               (cfg_we),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata),
    .in_mode              (in_ch.mode),
    .in_raw_count         (in_ch.raw_count),
    .out_ready            (out_ch.ready),
    .out_valid            (out_ch.valid),
    .out_filtered_percent (out_ch.filtered_percent),
    .out_latest_percent   (out_ch.latest_percent),
    .out_timer_period     (out_ch.timer_period),
    .out_held_samples     (out_ch.held_samples)
  );

  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("accepted word did not start work");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.filtered_percent <= ltmf_pkg::PCT_W'(ltmf_pkg::PCT_FULL))
                  && (out_ch.latest_percent <= ltmf_pkg::PCT_W'(ltmf_pkg::PCT_FULL))
                  && (out_ch.held_samples <= ltmf_pkg::CNT_W'(ltmf_pkg::WIN_SIZE)))
    else $error("result field out of range");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.held_samples == '0 |->
      out_ch.filtered_percent == '0 && out_ch.latest_percent == '0)
    else $error("empty window reported nonzero percent");

endmodule

@@ rtl/core/ltmf_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on ltmf_pkg for operand widths.
module ltmf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ltmf_pkg::DIV_DW-1:0] dividend,
  input  logic [ltmf_pkg::DIV_VW-1:0] divisor,
  output logic                        done,
  output logic [ltmf_pkg::DIV_DW-1:0] quotient
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [ltmf_pkg::DIV_CW-1:0] cnt_r, cnt_nxt;
  logic [ltmf_pkg::DIV_DW-1:0] quo_r, quo_nxt;
  logic [ltmf_pkg::DIV_VW-1:0] rem_r, rem_nxt;
  logic [ltmf_pkg::DIV_VW-1:0] dvs_r, dvs_nxt;
  logic [ltmf_pkg::DIV_VW:0]   trial;
  logic [ltmf_pkg::DIV_VW:0]   diff;

  assign trial = {rem_r, quo_r[ltmf_pkg::DIV_DW-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[ltmf_pkg::DIV_VW-1:0];
        quo_nxt = {quo_r[ltmf_pkg::DIV_DW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[ltmf_pkg::DIV_VW-1:0];
        quo_nxt = {quo_r[ltmf_pkg::DIV_DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ltmf_pkg::DIV_CW'(ltmf_pkg::DIV_DW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/core/ltmf_datapath.sv @@
// Datapath of the light trimmed mean filter: registers, sample window,
// rank pipeline, shared divider and result register.
// Depends on ltmf_pkg and ltmf_div.
module ltmf_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ltmf_pkg::cmd_t               cmd,
  output ltmf_pkg::sts_t               sts,
  input  logic                         cfg_we,
  input  logic [ltmf_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [ltmf_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                         in_mode,
  input  logic [ltmf_pkg::RAW_W-1:0]   in_raw_count,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [ltmf_pkg::PCT_W-1:0]   out_filtered_percent,
  output logic [ltmf_pkg::PCT_W-1:0]   out_latest_percent,
  output logic [ltmf_pkg::PER_W-1:0]   out_timer_period,
  output logic [ltmf_pkg::CNT_W-1:0]   out_held_samples
);

  localparam int W = ltmf_pkg::WIN_SIZE;
  localparam int GRP_PAD = ltmf_pkg::GRP_CNT * ltmf_pkg::GRP_N;

  logic [ltmf_pkg::RAW_W-1:0]  fs_r;
  logic [ltmf_pkg::TRIM_W-1:0] trim_r;
  logic [ltmf_pkg::PER_W-1:0]  plow_r;
  logic [ltmf_pkg::PER_W-1:0]  phigh_r;

  logic [ltmf_pkg::RAW_W-1:0]  raw_r;
  logic [ltmf_pkg::PCT_W-1:0]  pct_r;
  logic [ltmf_pkg::PCT_W-1:0]  filt_r;
  logic [ltmf_pkg::PER_W-1:0]  per_r;
  ltmf_pkg::div_op_t           op_r;

  logic [ltmf_pkg::PCT_W-1:0]  win_r [W];
  logic [W-1:0]                vld_r;
  logic [ltmf_pkg::CNT_W-1:0]  n_r;
  logic [ltmf_pkg::CNT_W-1:0]  rot_cnt_r;

  logic [W-1:0]                flag_nxt, flag_r;
  logic [ltmf_pkg::PCT_W-1:0]  b_val_r;
  logic                        b_vld_r, stb_r;
  logic [GRP_PAD-1:0]          flag_pad;
  logic [ltmf_pkg::GRP_W-1:0]  grp_nxt [ltmf_pkg::GRP_CNT];
  logic [ltmf_pkg::GRP_W-1:0]  grp_r   [ltmf_pkg::GRP_CNT];
  logic [ltmf_pkg::PCT_W-1:0]  c_val_r;
  logic                        c_vld_r, stc_r;
  logic [ltmf_pkg::CNT_W-1:0]  rank;
  logic [ltmf_pkg::SUM_W-1:0]  sum_r;

  logic [ltmf_pkg::THR_W-1:0]  thr;
  logic                        trim_on;
  logic [ltmf_pkg::CNT_W-1:0]  lo, hi, keep;
  logic [ltmf_pkg::PER_W-1:0]  span;

  logic                        div_done;
  logic [ltmf_pkg::DIV_DW-1:0] div_q;
  logic [ltmf_pkg::DIV_DW-1:0] div_a;
  logic [ltmf_pkg::DIV_VW-1:0] div_b;

  logic                        out_vld_r;
  logic [ltmf_pkg::PCT_W-1:0]  out_filt_r, out_last_r;
  logic [ltmf_pkg::PER_W-1:0]  out_per_r;
  logic [ltmf_pkg::CNT_W-1:0]  out_held_r;
  logic                        out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fs_r    <= ltmf_pkg::FS_RST;
      trim_r  <= ltmf_pkg::TRIM_RST;
      plow_r  <= ltmf_pkg::PLOW_RST;
      phigh_r <= ltmf_pkg::PHI_RST;
    end else if (cfg_we) begin
      unique case (ltmf_pkg::cfg_idx_t'(cfg_addr))
        ltmf_pkg::CFG_FULL_SCALE: fs_r    <= cfg_wdata[ltmf_pkg::RAW_W-1:0];
        ltmf_pkg::CFG_TRIM:       trim_r  <= cfg_wdata[ltmf_pkg::TRIM_W-1:0];
        ltmf_pkg::CFG_PER_LOW:    plow_r  <= cfg_wdata[ltmf_pkg::PER_W-1:0];
        ltmf_pkg::CFG_PER_HIGH:   phigh_r <= cfg_wdata[ltmf_pkg::PER_W-1:0];
      endcase
    end
  end

  // trim window bounds over the held samples
  assign thr     = {1'b0, trim_r, 1'b0} + ltmf_pkg::THR_W'(3);
  assign trim_on = {{(ltmf_pkg::THR_W - ltmf_pkg::CNT_W){1'b0}}, n_r} > thr;
  assign lo      = trim_on ? ltmf_pkg::CNT_W'(trim_r) : '0;
  assign hi      = trim_on ? n_r - ltmf_pkg::CNT_W'(trim_r) : n_r;
  assign keep    = hi - lo;
  assign span    = (phigh_r >= plow_r) ? phigh_r - plow_r : '0;

  always_comb begin
    unique case (cmd.div_op)
      ltmf_pkg::DIV_PCT: begin
        div_a = ltmf_pkg::DIV_DW'(raw_r) * ltmf_pkg::DIV_DW'(ltmf_pkg::PCT_FULL);
        div_b = (fs_r == '0) ? ltmf_pkg::DIV_VW'(1) : fs_r;
      end
      ltmf_pkg::DIV_MEAN: begin
        div_a = ltmf_pkg::DIV_DW'(sum_r);
        div_b = ltmf_pkg::DIV_VW'(keep);
      end
      default: begin
        div_a = ltmf_pkg::DIV_DW'(span) * ltmf_pkg::DIV_DW'(filt_r);
        div_b = ltmf_pkg::DIV_VW'(ltmf_pkg::PCT_FULL);
      end
    endcase
  end

  ltmf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      raw_r  <= in_raw_count;
      filt_r <= '0;
    end else if (div_done && op_r == ltmf_pkg::DIV_MEAN) begin
      filt_r <= div_q[ltmf_pkg::PCT_W-1:0];
    end
    if (cmd.div_start) begin
      op_r <= cmd.div_op;
    end
    if (div_done && op_r == ltmf_pkg::DIV_PCT) begin
      pct_r <= (div_q > ltmf_pkg::DIV_DW'(ltmf_pkg::PCT_FULL))
             ? ltmf_pkg::PCT_W'(ltmf_pkg::PCT_FULL) : div_q[ltmf_pkg::PCT_W-1:0];
    end
    if (div_done && op_r == ltmf_pkg::DIV_PER) begin
      per_r <= plow_r + div_q[ltmf_pkg::PER_W-1:0];
    end
  end

  // window: push at tap 0, rotate toward tap 0 during the rank pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      n_r       <= '0;
      rot_cnt_r <= '0;
    end else begin
      if (cmd.push) begin
        vld_r <= {vld_r[W-2:0], 1'b1};
        if (n_r != ltmf_pkg::CNT_W'(W)) begin
          n_r <= n_r + 1'b1;
        end
      end else if (cmd.rank_step) begin
        vld_r <= {vld_r[0], vld_r[W-1:1]};
      end
      if (cmd.load_in) begin
        rot_cnt_r <= '0;
      end else if (cmd.rank_step) begin
        rot_cnt_r <= rot_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      win_r[0] <= pct_r;
      for (int k = 1; k < W; k++) begin
        win_r[k] <= win_r[k-1];
      end
    end else if (cmd.rank_step) begin
      win_r[W-1] <= win_r[0];
      for (int k = 0; k < W - 1; k++) begin
        win_r[k] <= win_r[k+1];
      end
    end
  end

  // rank of tap 0: smaller values, and equal values from earlier slots
  always_comb begin
    for (int k = 0; k < W; k++) begin
      flag_nxt[k] = vld_r[k] && ((win_r[k] < win_r[0]) ||
                    ((win_r[k] == win_r[0]) && (int'(rot_cnt_r) + k >= W)));
    end
  end

  assign flag_pad = GRP_PAD'(flag_r);

  always_comb begin
    for (int g = 0; g < ltmf_pkg::GRP_CNT; g++) begin
      grp_nxt[g] = ltmf_pkg::GRP_W'($countones(flag_pad[g*ltmf_pkg::GRP_N +: ltmf_pkg::GRP_N]));
    end
  end

  always_comb begin
    rank = '0;
    for (int g = 0; g < ltmf_pkg::GRP_CNT; g++) begin
      rank = rank + ltmf_pkg::CNT_W'(grp_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stb_r <= 1'b0;
      stc_r <= 1'b0;
    end else begin
      stb_r <= cmd.rank_step;
      stc_r <= stb_r;
    end
  end

  always_ff @(posedge clk) begin
    flag_r  <= flag_nxt;
    b_val_r <= win_r[0];
    b_vld_r <= vld_r[0];
    grp_r   <= grp_nxt;
    c_val_r <= b_val_r;
    c_vld_r <= b_vld_r;
    if (cmd.load_in) begin
      sum_r <= '0;
    end else if (stc_r && c_vld_r && rank >= lo && rank < hi) begin
      sum_r <= sum_r + ltmf_pkg::SUM_W'(c_val_r);
    end
  end

  assign out_free = !out_vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.emit) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_filt_r <= filt_r;
      out_last_r <= vld_r[0] ? win_r[0] : '0;
      out_per_r  <= per_r;
      out_held_r <= n_r;
    end
  end

  assign sts.add_sample = !in_mode;
  assign sts.div_done   = div_done;
  assign sts.rot_last   = (rot_cnt_r == ltmf_pkg::CNT_W'(W - 1));
  assign sts.rank_busy  = stb_r || stc_r;
  assign sts.n_zero     = (n_r == '0);
  assign sts.out_free   = out_free;

  assign out_valid            = out_vld_r;
  assign out_filtered_percent = out_filt_r;
  assign out_latest_percent   = out_last_r;
  assign out_timer_period     = out_per_r;
  assign out_held_samples     = out_held_r;

endmodule

@@ rtl/core/ltmf_ctrl.sv @@
// Controller of the light trimmed mean filter: sequences scaling, window
// update, rank pass and the two divisions. Depends on ltmf_pkg.
module ltmf_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ltmf_pkg::sts_t sts,
  output ltmf_pkg::cmd_t cmd
);

  ltmf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ltmf_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd.load_in   = 1'b0;
    cmd.div_start = 1'b0;
    cmd.div_op    = ltmf_pkg::DIV_PCT;
    cmd.push      = 1'b0;
    cmd.rank_step = 1'b0;
    cmd.emit      = 1'b0;
    unique case (state_r)
      ltmf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = sts.add_sample ? ltmf_pkg::ST_PCT_GO : ltmf_pkg::ST_RANK;
        end
      end
      ltmf_pkg::ST_PCT_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ltmf_pkg::ST_PCT_WAIT;
      end
      ltmf_pkg::ST_PCT_WAIT: begin
        if (sts.div_done) begin
          state_nxt = ltmf_pkg::ST_PUSH;
        end
      end
      ltmf_pkg::ST_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = ltmf_pkg::ST_RANK;
      end
      ltmf_pkg::ST_RANK: begin
        cmd.rank_step = 1'b1;
        if (sts.rot_last) begin
          state_nxt = ltmf_pkg::ST_DRAIN;
        end
      end
      ltmf_pkg::ST_DRAIN: begin
        if (!sts.rank_busy) begin
          state_nxt = sts.n_zero ? ltmf_pkg::ST_PER_GO : ltmf_pkg::ST_MEAN_GO;
        end
      end
      ltmf_pkg::ST_MEAN_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = ltmf_pkg::DIV_MEAN;
        state_nxt     = ltmf_pkg::ST_MEAN_WAIT;
      end
      ltmf_pkg::ST_MEAN_WAIT: begin
        if (sts.div_done) begin
          state_nxt = ltmf_pkg::ST_PER_GO;
        end
      end
      ltmf_pkg::ST_PER_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = ltmf_pkg::DIV_PER;
        state_nxt     = ltmf_pkg::ST_PER_WAIT;
      end
      ltmf_pkg::ST_PER_WAIT: begin
        if (sts.div_done) begin
          state_nxt = ltmf_pkg::ST_EMIT;
        end
      end
      ltmf_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ltmf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ltmf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
